/* hdl/fep_pkg.sv */
// Package for the field header and length prefix encoder.
// Holds the transaction types, command and status codes, and queue sizing.
// No dependencies.
`default_nettype none

package fep_pkg;

  // Width of the running byte offset; the reported start offset is its low 32 bits.
  localparam int OFFSET_WIDTH = 32;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [2:0] CMD_HEADER = 3'd0;
  localparam logic [2:0] CMD_PREFIX = 3'd1;
  localparam logic [2:0] CMD_U8     = 3'd2;
  localparam logic [2:0] CMD_U16    = 3'd3;
  localparam logic [2:0] CMD_U32    = 3'd4;
  localparam logic [2:0] CMD_U64    = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_CODE = 2'd1;
  localparam logic [1:0] ST_LEN_RANGE = 2'd2;

  // Length prefix band limits.
  localparam logic [19:0] PFX_ONE_MAX   = 20'd192;
  localparam logic [19:0] PFX_TWO_BASE  = 20'd193;
  localparam logic [19:0] PFX_TWO_MAX   = 20'd12480;
  localparam logic [7:0]  PFX_THREE_TAG = 8'd241;
  localparam logic [19:0] PFX_THREE_BASE = 20'd12481;
  localparam logic [19:0] PFX_THREE_MAX = 20'd918744;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  type_code;
    logic [7:0]  name_code;
    logic [19:0] payload_length;
    logic [63:0] int_value;
  } fep_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last_byte;
    logic [1:0]  status;
    logic [31:0] start_offset;
  } fep_result_t;

  // One classified item: bytes in send order, index of the final byte.
  typedef struct packed {
    logic [7:0][7:0] bytes;
    logic [2:0]      last_idx;
    logic [1:0]      status;
    logic [31:0]     start_offset;
  } fep_entry_t;

endpackage

`default_nettype wire

/* hdl/fep_front.sv */
// Front end: accepts items, encodes them into a byte list and tracks the offset.
// Depends on fep_pkg.
`default_nettype none

module fep_front
  import fep_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  input  wire fep_item_t  item,
  input  wire logic       q_full,
  output logic            item_stall,
  output logic            q_push,
  output fep_entry_t      q_entry
);

  logic [OFFSET_WIDTH-1:0] bytes_written;
  logic [OFFSET_WIDTH-1:0] bytes_written_next;
  logic                    known_cmd;
  logic [19:0]             m_two;
  logic [19:0]             m_three;
  logic [63:0]             int_shifted;
  logic [2:0]              int_last;

  assign item_stall = q_full;

  assign m_two   = item.payload_length - PFX_TWO_BASE;
  assign m_three = item.payload_length - PFX_THREE_BASE;

  always_comb begin
    q_entry              = '0;
    q_entry.start_offset = 32'(bytes_written);
    q_entry.status       = ST_OK;
    known_cmd            = 1'b1;
    int_shifted          = item.int_value;
    int_last             = 3'd7;
    case (item.cmd)
      CMD_HEADER: begin
        if (item.type_code == 8'd0 || item.name_code == 8'd0) begin
          q_entry.status = ST_ZERO_CODE;
        end else if (item.type_code[7:4] == 4'd0) begin
          if (item.name_code[7:4] == 4'd0) begin
            q_entry.bytes[0] = {item.type_code[3:0], item.name_code[3:0]};
          end else begin
            q_entry.bytes[0] = {item.type_code[3:0], 4'd0};
            q_entry.bytes[1] = item.name_code;
            q_entry.last_idx = 3'd1;
          end
        end else if (item.name_code[7:4] == 4'd0) begin
          q_entry.bytes[0] = item.name_code;
          q_entry.bytes[1] = item.type_code;
          q_entry.last_idx = 3'd1;
        end else begin
          q_entry.bytes[1] = item.type_code;
          q_entry.bytes[2] = item.name_code;
          q_entry.last_idx = 3'd2;
        end
      end
      CMD_PREFIX: begin
        if (item.payload_length <= PFX_ONE_MAX) begin
          q_entry.bytes[0] = item.payload_length[7:0];
        end else if (item.payload_length <= PFX_TWO_MAX) begin
          q_entry.bytes[0] = PFX_TWO_BASE[7:0] + {2'd0, m_two[13:8]};
          q_entry.bytes[1] = m_two[7:0];
          q_entry.last_idx = 3'd1;
        end else if (item.payload_length <= PFX_THREE_MAX) begin
          q_entry.bytes[0] = PFX_THREE_TAG + {4'd0, m_three[19:16]};
          q_entry.bytes[1] = m_three[15:8];
          q_entry.bytes[2] = m_three[7:0];
          q_entry.last_idx = 3'd2;
        end else begin
          q_entry.status = ST_LEN_RANGE;
        end
      end
      CMD_U8: begin
        int_shifted = item.int_value << 56;
        int_last    = 3'd0;
      end
      CMD_U16: begin
        int_shifted = item.int_value << 48;
        int_last    = 3'd1;
      end
      CMD_U32: begin
        int_shifted = item.int_value << 32;
        int_last    = 3'd3;
      end
      CMD_U64: begin
        int_shifted = item.int_value;
        int_last    = 3'd7;
      end
      default: begin
        known_cmd = 1'b0;
      end
    endcase
    // Integers go out big-endian: left-align them and take bytes from the top.
    if (item.cmd == CMD_U8 || item.cmd == CMD_U16 || item.cmd == CMD_U32 ||
        item.cmd == CMD_U64) begin
      for (int i = 0; i < 8; i++) begin
        q_entry.bytes[i] = int_shifted[63 - 8*i -: 8];
      end
      q_entry.last_idx = int_last;
    end
  end

  // Unused command codes are consumed without leaving anything in the queue.
  assign q_push = item_valid && !q_full && known_cmd;

  always_comb begin
    bytes_written_next = bytes_written;
    if (q_push && q_entry.status == ST_OK) begin
      bytes_written_next = bytes_written + OFFSET_WIDTH'(q_entry.last_idx) +
                           OFFSET_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_written <= '0;
    end else begin
      bytes_written <= bytes_written_next;
    end
  end

  // Error entries always carry a single byte.
  assert property (@(posedge clk) disable iff (rst)
    q_push && q_entry.status != ST_OK |-> q_entry.last_idx == 3'd0)
    else $error("error entry with more than one byte");

endmodule

`default_nettype wire

/* hdl/fep_queue.sv */
// Short queue of encoded entries between the front and back ends.
// Depends on fep_pkg.
`default_nettype none

module fep_queue
  import fep_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire fep_entry_t push_entry,
  input  wire logic       pop,
  output logic            full,
  output logic            not_empty,
  output fep_entry_t      head
);

  fep_entry_t        slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst) !(pop && !not_empty))
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) count <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

/* hdl/fep_back.sv */
// Back end: sends the bytes of each queued entry, one per cycle while result_stall
// is low, through a registered output stage. Depends on fep_pkg.
`default_nettype none

module fep_back
  import fep_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_not_empty,
  input  wire fep_entry_t q_head,
  output logic            q_pop,
  output logic            result_valid,
  input  wire logic       result_stall,
  output fep_result_t     result
);

  logic [2:0] idx;
  logic       advance;
  logic       at_last;

  assign advance = !result_valid || !result_stall;
  assign at_last = (idx == q_head.last_idx);
  assign q_pop   = advance && q_not_empty && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      idx          <= '0;
    end else if (advance) begin
      result_valid <= q_not_empty;
      if (q_not_empty) begin
        idx <= at_last ? 3'd0 : idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && q_not_empty) begin
      result.out_byte     <= q_head.bytes[idx];
      result.last_byte    <= at_last;
      result.status       <= q_head.status;
      result.start_offset <= q_head.start_offset;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    q_not_empty |-> idx <= q_head.last_idx)
    else $error("byte index past end of entry");
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_OK |-> result.last_byte && result.out_byte == 8'd0)
    else $error("error result is not a single zero byte");
  assert property (@(posedge clk) disable iff (rst)
    !q_not_empty |-> idx == 3'd0)
    else $error("byte index left mid-entry with empty queue");

endmodule

`default_nettype wire

/* hdl/field_header_and_length_prefix_encoder.sv */
// Top level of the field header and length prefix encoder.
// Depends on fep_pkg, fep_front, fep_queue and fep_back.
//
// Each accepted item becomes one transaction per encoded byte on the result
// channel, with last_byte on the final one: a field header takes 1 to 3 bytes,
// a length prefix 1 to 3, an integer 1, 2, 4 or 8, and a zero code or an
// oversized length gives one zero byte with a nonzero status. Command codes 6
// and 7 are taken and dropped. Bytes leave through the single registered output
// byte at one byte per cycle while result_stall is low; a new item may be
// accepted every cycle while the two-entry queue has room. An accepted item is
// written into the queue, and its first byte is then registered into the output
// stage. start_offset is the running count of ok bytes before the item, modulo
// 2^OFFSET_WIDTH.
`default_nettype none

module field_header_and_length_prefix_encoder
  import fep_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire fep_item_t   item,
  output logic             result_valid,
  input  wire logic        result_stall,
  output fep_result_t      result
);

  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_not_empty;
  fep_entry_t q_entry;
  fep_entry_t q_head;

  fep_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .q_full     (q_full),
    .item_stall (item_stall),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  fep_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  fep_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (q_not_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Testbench for field_header_and_length_prefix_encoder: directed and random items,
// random idling on both channels, results checked byte by byte by a scoreboard.
// Depends on fep_pkg and the encoder RTL.

module testbench;
  import fep_pkg::*;

  // Predicts the byte stream of each accepted item and checks results in order.
  class encode_scoreboard;
    fep_result_t expected_bytes[$];
    logic [31:0] byte_offset;
    int unsigned mismatches;

    function new();
      byte_offset = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void note_item(fep_item_t it);
      logic [7:0]  enc [8];
      logic [1:0]  st;
      logic [19:0] rem;
      fep_result_t r;
      int          n;
      int          width;
      int          i;
      st = ST_OK;
      n = 0;
      width = 0;
      case (it.cmd)
        CMD_HEADER: begin
          if (it.type_code == 8'd0 || it.name_code == 8'd0) begin
            st = ST_ZERO_CODE;
          end else if (it.type_code < 8'd16 && it.name_code < 8'd16) begin
            enc[0] = {it.type_code[3:0], it.name_code[3:0]};
            n = 1;
          end else if (it.type_code < 8'd16) begin
            enc[0] = {it.type_code[3:0], 4'h0};
            enc[1] = it.name_code;
            n = 2;
          end else if (it.name_code < 8'd16) begin
            enc[0] = it.name_code;
            enc[1] = it.type_code;
            n = 2;
          end else begin
            enc[0] = 8'h00;
            enc[1] = it.type_code;
            enc[2] = it.name_code;
            n = 3;
          end
        end
        CMD_PREFIX: begin
          if (it.payload_length <= PFX_ONE_MAX) begin
            enc[0] = it.payload_length[7:0];
            n = 1;
          end else if (it.payload_length <= PFX_TWO_MAX) begin
            rem = it.payload_length - PFX_TWO_BASE;
            enc[0] = PFX_TWO_BASE[7:0] + rem[15:8];
            enc[1] = rem[7:0];
            n = 2;
          end else if (it.payload_length <= PFX_THREE_MAX) begin
            rem = it.payload_length - PFX_THREE_BASE;
            enc[0] = PFX_THREE_TAG + {4'h0, rem[19:16]};
            enc[1] = rem[15:8];
            enc[2] = rem[7:0];
            n = 3;
          end else begin
            st = ST_LEN_RANGE;
          end
        end
        CMD_U8:  width = 1;
        CMD_U16: width = 2;
        CMD_U32: width = 4;
        CMD_U64: width = 8;
        default: return;
      endcase
      // Integers go out most significant byte first.
      for (i = 0; i < width; i++) begin
        enc[i] = it.int_value[8 * (width - 1 - i) +: 8];
      end
      if (width != 0) n = width;

      r.start_offset = byte_offset;
      r.status = st;
      if (st != ST_OK) begin
        r.out_byte = 8'h00;
        r.last_byte = 1'b1;
        expected_bytes = {expected_bytes, r};
      end else begin
        for (i = 0; i < n; i++) begin
          r.out_byte = enc[i];
          r.last_byte = (i == n - 1);
          expected_bytes = {expected_bytes, r};
        end
        byte_offset = byte_offset + n;
      end
    endfunction

    function void check_result(fep_result_t got);
      fep_result_t want;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: unexpected result byte %02h last %0d status %0d offset %0d",
                   $time, got.out_byte, got.last_byte, got.status, got.start_offset);
        end
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.last_byte !== want.last_byte ||
          got.status !== want.status || got.start_offset !== want.start_offset) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: expected byte %02h last %0d status %0d offset %0d", $time,
                   want.out_byte, want.last_byte, want.status, want.start_offset);
          $display("%0t:      got byte %02h last %0d status %0d offset %0d", $time,
                   got.out_byte, got.last_byte, got.status, got.start_offset);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  fep_item_t   item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  fep_result_t result;
  logic        quiet_mode = 1'b0;

  encode_scoreboard sb = new();

  field_header_and_length_prefix_encoder DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Record every input transaction as it is taken.
  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) sb.note_item(item);
  end

  // Result side: check each accepted transaction, then pick the next stall.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
    result_stall <= !quiet_mode && ($urandom_range(0, 99) < 34);
  end

  task automatic send_item(input fep_item_t it);
    while (!quiet_mode && $urandom_range(0, 99) < 34) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // The first edge lets the monitor record a transaction taken at the same edge.
  task automatic wait_drained();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic fep_item_t make_item(logic [2:0] cmd, logic [7:0] type_code,
                                          logic [7:0] name_code, logic [19:0] len,
                                          logic [63:0] value);
    fep_item_t it;
    it.cmd = cmd;
    it.type_code = type_code;
    it.name_code = name_code;
    it.payload_length = len;
    it.int_value = value;
    return it;
  endfunction

  function automatic fep_item_t random_item();
    fep_item_t   it;
    logic [19:0] band_base;
    it.cmd = 3'($urandom_range(0, 5));
    it.type_code = 8'($urandom);
    it.name_code = 8'($urandom);
    it.payload_length = 20'($urandom);
    it.int_value = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 4) it.cmd = 3'($urandom_range(6, 7));
    case (it.cmd)
      CMD_HEADER: begin
        // Lean toward small codes so all four header layouts show up often.
        if ($urandom_range(0, 1)) it.type_code = 8'($urandom_range(1, 15));
        if ($urandom_range(0, 1)) it.name_code = 8'($urandom_range(1, 15));
        if ($urandom_range(0, 19) == 0) it.type_code = 8'h00;
        if ($urandom_range(0, 19) == 0) it.name_code = 8'h00;
      end
      CMD_PREFIX: begin
        case ($urandom_range(0, 4))
          0: it.payload_length = 20'($urandom_range(0, 192));
          1: it.payload_length = 20'($urandom_range(193, 12480));
          2: it.payload_length = 20'($urandom_range(12481, 918744));
          3: begin
            case ($urandom_range(0, 4))
              0:       band_base = PFX_ONE_MAX;
              1:       band_base = PFX_TWO_BASE;
              2:       band_base = PFX_TWO_MAX;
              3:       band_base = PFX_THREE_BASE;
              default: band_base = PFX_THREE_MAX;
            endcase
            it.payload_length = band_base - 20'd1 + 20'($urandom_range(0, 2));
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return it;
  endfunction

  initial begin
    fep_item_t   it;
    int          counted;
    logic [63:0] ones;
    ones = '1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Header layouts, code boundaries and zero codes.
    send_item(make_item(CMD_HEADER, 8'd1, 8'd1, '0, '0));
    send_item(make_item(CMD_HEADER, 8'd15, 8'd15, '1, ones));
    send_item(make_item(CMD_HEADER, 8'd15, 8'd255, '0, '0));
    send_item(make_item(CMD_HEADER, 8'd255, 8'd15, '0, '0));
    send_item(make_item(CMD_HEADER, 8'd255, 8'd255, '0, '0));
    send_item(make_item(CMD_HEADER, 8'd16, 8'd16, '0, '0));
    send_item(make_item(CMD_HEADER, 8'd0, 8'd5, '0, '0));
    send_item(make_item(CMD_HEADER, 8'd5, 8'd0, '0, '0));
    send_item(make_item(CMD_HEADER, 8'd0, 8'd0, '0, '0));
    // Length prefix at every band edge and beyond the top band.
    send_item(make_item(CMD_PREFIX, '0, '0, 20'd0, '0));
    send_item(make_item(CMD_PREFIX, '1, '1, PFX_ONE_MAX, ones));
    send_item(make_item(CMD_PREFIX, '0, '0, PFX_TWO_BASE, '0));
    send_item(make_item(CMD_PREFIX, '0, '0, PFX_TWO_MAX, '0));
    send_item(make_item(CMD_PREFIX, '0, '0, PFX_THREE_BASE, '0));
    send_item(make_item(CMD_PREFIX, '0, '0, PFX_THREE_MAX, '0));
    send_item(make_item(CMD_PREFIX, '0, '0, PFX_THREE_MAX + 20'd1, '0));
    send_item(make_item(CMD_PREFIX, '0, '0, '1, '0));
    // Integers of every width.
    send_item(make_item(CMD_U8, '0, '0, '0, ones));
    send_item(make_item(CMD_U16, '0, '0, '0, 64'h0123_4567_89ab_cdef));
    send_item(make_item(CMD_U32, '0, '0, '0, 64'h0123_4567_89ab_cdef));
    send_item(make_item(CMD_U64, '0, '0, '0, 64'h0123_4567_89ab_cdef));
    send_item(make_item(CMD_U64, '1, '1, '1, ones));
    send_item(make_item(CMD_U64, '0, '0, '0, '0));
    // Unused command codes are swallowed without output.
    send_item(make_item(3'd6, '1, '1, '1, ones));
    send_item(make_item(3'd7, '0, '0, '0, '0));

    // Hold off until the encoder has delivered everything so far.
    item_valid <= 1'b0;
    wait_drained();
    @(posedge clk);

    counted = 0;
    while (counted < 240) begin
      if (counted == 100) quiet_mode <= 1'b1;
      if (counted == 160) quiet_mode <= 1'b0;
      it = random_item();
      send_item(it);
      if (it.cmd <= CMD_U64) counted++;
    end
    item_valid <= 1'b0;

    wait_drained();
    repeat (16) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* field_header_and_length_prefix_encoder.f */
hdl/fep_pkg.sv
hdl/fep_front.sv
hdl/fep_queue.sv
hdl/fep_back.sv
hdl/field_header_and_length_prefix_encoder.sv
tb/sv/testbench.sv
